### sv/bmpdf_pkg.sv
// ----------------------------------------------------------------------------
// bmpdf_pkg
// Shared types, constants and helper functions for the BMP stream deframer.
// ----------------------------------------------------------------------------
package bmpdf_pkg;

  // dimension limits and widths
  localparam int MAX_DIM  = 4096;
  localparam int DIM_W    = 13;
  localparam int POS_W    = 32;
  localparam int QDEPTH   = 2;
  localparam int QCNT_W   = $clog2(QDEPTH + 1);
  localparam int QPTR_W   = $clog2(QDEPTH);

  // info header sizes
  localparam logic [31:0] HSZ_CORE   = 32'd12;
  localparam logic [31:0] HSZ_OS2_64 = 32'd64;
  localparam logic [31:0] HSZ_OS2_16 = 32'd16;
  localparam logic [31:0] HSZ_INFO40 = 32'd40;
  localparam logic [31:0] HSZ_V2     = 32'd52;
  localparam logic [31:0] HSZ_V3     = 32'd56;
  localparam logic [31:0] HSZ_V4     = 32'd108;
  localparam logic [31:0] HSZ_V5     = 32'd124;

  // dense header kind codes
  localparam logic [3:0] KIND_NONE   = 4'd0;
  localparam logic [3:0] KIND_CORE   = 4'd1;
  localparam logic [3:0] KIND_OS2_64 = 4'd2;
  localparam logic [3:0] KIND_OS2_16 = 4'd3;
  localparam logic [3:0] KIND_INFO40 = 4'd4;
  localparam logic [3:0] KIND_V2     = 4'd5;
  localparam logic [3:0] KIND_V3     = 4'd6;
  localparam logic [3:0] KIND_V4     = 4'd7;
  localparam logic [3:0] KIND_V5     = 4'd8;

  // header field that a byte position belongs to
  typedef enum logic [3:0] {
    FLD_NONE,
    FLD_TYPE_HI,
    FLD_TYPE_LO,
    FLD_SIZE,
    FLD_OFFSET,
    FLD_HSIZE,
    FLD_WIDTH,
    FLD_HEIGHT,
    FLD_DEPTH
  } field_t;

  // pixel phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ACTIVE,
    PH_DONE
  } phase_t;

  // classified byte travelling from front to back
  typedef struct packed {
    logic [7:0]       data_byte;
    logic             file_start;
    logic [POS_W-1:0] pos;
    logic             base_hdr;
    field_t           fld;
    logic [1:0]       lane;
  } entry_t;

  // queue status
  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              push;
    logic              pop;
  } qstat_t;

  function automatic logic [3:0] decode_kind(input logic [31:0] s);
    logic [3:0] k;
    unique case (s)
      HSZ_CORE:   k = KIND_CORE;
      HSZ_OS2_64: k = KIND_OS2_64;
      HSZ_OS2_16: k = KIND_OS2_16;
      HSZ_INFO40: k = KIND_INFO40;
      HSZ_V2:     k = KIND_V2;
      HSZ_V3:     k = KIND_V3;
      HSZ_V4:     k = KIND_V4;
      HSZ_V5:     k = KIND_V5;
      default:    k = KIND_NONE;
    endcase
    return k;
  endfunction

  // signed 32-bit dimension clamped to 0 .. MAX_DIM
  function automatic logic [DIM_W-1:0] sat_dim(input logic [31:0] v);
    logic [DIM_W-1:0] r;
    if (v[31]) begin
      r = '0;
    end else if (v > 32'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v[DIM_W-1:0];
    end
    return r;
  endfunction

endpackage

### sv/bmpdf_if.sv
// ----------------------------------------------------------------------------
// bmpdf interfaces
// Valid/ready channels for file bytes in and deframed results out.
// ----------------------------------------------------------------------------
interface bmpdf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

interface bmpdf_result_if;
  logic        valid;
  logic        ready;
  logic        pixel_valid;
  logic [11:0] pixel_row;
  logic [11:0] pixel_column;
  logic [1:0]  pixel_channel;
  logic [7:0]  pixel_value;
  logic [15:0] file_type;
  logic [31:0] file_size;
  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [15:0] color_depth;
  logic [31:0] data_offset;
  logic [3:0]  header_kind;

  modport source (
    output valid, output pixel_valid, output pixel_row, output pixel_column,
    output pixel_channel, output pixel_value, output file_type, output file_size,
    output image_width, output image_height, output color_depth,
    output data_offset, output header_kind, input ready
  );
  modport sink (
    input valid, input pixel_valid, input pixel_row, input pixel_column,
    input pixel_channel, input pixel_value, input file_type, input file_size,
    input image_width, input image_height, input color_depth,
    input data_offset, input header_kind, output ready
  );
endinterface

### sv/bmpdf_front.sv
// ----------------------------------------------------------------------------
// bmpdf_front
// Accepts file bytes, tracks the byte position and tags each byte with the
// header field and byte lane it falls in.
// ----------------------------------------------------------------------------
module bmpdf_front import bmpdf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  bmpdf_byte_if.sink       file_bytes,
  output logic             push_valid,
  input  logic             push_ready,
  output entry_t           push_entry
);

  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] byte_position_next;
  logic [POS_W-1:0] pos_now;
  logic [4:0]       pos_lo;
  logic             near_start;
  logic             fire;

  assign file_bytes.ready = push_ready;
  assign push_valid       = file_bytes.valid;
  assign fire             = file_bytes.valid && push_ready;

  // a file start byte is always position zero
  assign pos_now    = file_bytes.file_start ? '0 : byte_position;
  assign pos_lo     = pos_now[4:0];
  assign near_start = (pos_now < POS_W'(32));

  // saturating position counter
  assign byte_position_next = (pos_now == '1) ? pos_now : pos_now + POS_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (fire) begin
      byte_position <= byte_position_next;
    end
  end

  // field classification by position
  always_comb begin
    push_entry.data_byte  = file_bytes.data_byte;
    push_entry.file_start = file_bytes.file_start;
    push_entry.pos        = pos_now;
    push_entry.base_hdr   = (pos_now < POS_W'(18));
    push_entry.fld        = FLD_NONE;
    push_entry.lane       = '0;
    if (near_start) begin
      if (pos_lo == 5'd0) begin
        push_entry.fld = FLD_TYPE_HI;
      end else if (pos_lo == 5'd1) begin
        push_entry.fld = FLD_TYPE_LO;
      end else if (pos_lo >= 5'd2 && pos_lo <= 5'd5) begin
        push_entry.fld  = FLD_SIZE;
        push_entry.lane = 2'(pos_lo - 5'd2);
      end else if (pos_lo >= 5'd10 && pos_lo <= 5'd13) begin
        push_entry.fld  = FLD_OFFSET;
        push_entry.lane = 2'(pos_lo - 5'd10);
      end else if (pos_lo >= 5'd14 && pos_lo <= 5'd17) begin
        push_entry.fld  = FLD_HSIZE;
        push_entry.lane = 2'(pos_lo - 5'd14);
      end else if (pos_lo >= 5'd18 && pos_lo <= 5'd21) begin
        push_entry.fld  = FLD_WIDTH;
        push_entry.lane = 2'(pos_lo - 5'd18);
      end else if (pos_lo >= 5'd22 && pos_lo <= 5'd25) begin
        push_entry.fld  = FLD_HEIGHT;
        push_entry.lane = 2'(pos_lo - 5'd22);
      end else if (pos_lo == 5'd28 || pos_lo == 5'd29) begin
        push_entry.fld  = FLD_DEPTH;
        push_entry.lane = 2'(pos_lo - 5'd28);
      end
    end
  end

endmodule

### sv/bmpdf_queue.sv
// ----------------------------------------------------------------------------
// bmpdf_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module bmpdf_queue import bmpdf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_entry,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_entry,
  output qstat_t status
);

  entry_t            slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = (count != QCNT_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = slots[rd_ptr];

  assign status.count = count;
  assign status.push  = push;
  assign status.pop   = pop;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

### sv/bmpdf_back.sv
// ----------------------------------------------------------------------------
// bmpdf_back
// Captures header fields, runs the pixel counters and holds the result
// register that drives the output channel.
// ----------------------------------------------------------------------------
module bmpdf_back import bmpdf_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  entry_t          pop_entry,
  bmpdf_result_if.source  results
);

  // header and pixel state
  logic [31:0]      field_shift, field_shift_next;
  logic [15:0]      type_reg, type_reg_next;
  logic [31:0]      size_reg, size_reg_next;
  logic [31:0]      offset_reg, offset_reg_next;
  logic [31:0]      header_size_reg, header_size_reg_next;
  logic [3:0]       kind_reg, kind_reg_next;
  logic [DIM_W-1:0] width_reg, width_reg_next;
  logic [DIM_W-1:0] height_reg, height_reg_next;
  logic [15:0]      depth_reg, depth_reg_next;
  logic [DIM_W-1:0] row, row_next;
  logic [DIM_W-1:0] col, col_next;
  logic [1:0]       chan, chan_next;
  phase_t           phase, phase_next;
  logic [1:0]       pad_count, pad_count_next;

  logic             emit;
  logic [11:0]      prow, pcol;
  logic [1:0]       pch;
  logic             fire;
  logic             out_valid;

  assign pop_ready     = !out_valid || results.ready;
  assign fire          = pop_valid && pop_ready;
  assign results.valid = out_valid;

  // next state for the byte at the head of the queue
  always_comb begin
    logic [31:0]      shifted;
    logic             hdr;
    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;
    logic             fs;

    fs      = pop_entry.file_start;
    shifted = {24'd0, pop_entry.data_byte} << {pop_entry.lane, 3'b000};

    // a file start clears everything before the byte is used
    field_shift_next     = fs ? '0 : field_shift;
    type_reg_next        = fs ? '0 : type_reg;
    size_reg_next        = fs ? '0 : size_reg;
    offset_reg_next      = fs ? '0 : offset_reg;
    header_size_reg_next = fs ? '0 : header_size_reg;
    kind_reg_next        = fs ? KIND_NONE : kind_reg;
    width_reg_next       = fs ? '0 : width_reg;
    height_reg_next      = fs ? '0 : height_reg;
    depth_reg_next       = fs ? '0 : depth_reg;
    row_next             = fs ? '0 : row;
    col_next             = fs ? '0 : col;
    chan_next            = fs ? '0 : chan;
    phase_next           = fs ? PH_IDLE : phase;
    pad_count_next       = fs ? '0 : pad_count;

    emit = 1'b0;
    prow = '0;
    pcol = '0;
    pch  = '0;

    hdr = pop_entry.base_hdr ||
          (kind_reg_next == KIND_INFO40 &&
           (pop_entry.fld == FLD_WIDTH || pop_entry.fld == FLD_HEIGHT ||
            pop_entry.fld == FLD_DEPTH));

    if (phase_next == PH_ACTIVE) begin
      // active pixel phase: skip padding or emit
      if (pad_count_next != '0) begin
        pad_count_next = pad_count_next - 2'd1;
        if (pad_count_next == '0 && row_next >= height_reg_next) begin
          phase_next = PH_DONE;
        end
      end else begin
        emit = 1'b1;
      end
    end else if (hdr) begin
      // header capture
      unique case (pop_entry.fld)
        FLD_TYPE_HI: type_reg_next = {pop_entry.data_byte, 8'd0};
        FLD_TYPE_LO: type_reg_next = type_reg_next | {8'd0, pop_entry.data_byte};
        FLD_SIZE:    size_reg_next = size_reg_next | shifted;
        FLD_OFFSET:  offset_reg_next = offset_reg_next | shifted;
        FLD_HSIZE: begin
          header_size_reg_next = header_size_reg_next | shifted;
          if (pop_entry.lane == 2'd3) begin
            kind_reg_next = decode_kind(header_size_reg_next);
          end
        end
        FLD_WIDTH, FLD_HEIGHT: begin
          field_shift_next = (pop_entry.lane == 2'd0) ? shifted
                                                      : (field_shift_next | shifted);
          if (pop_entry.lane == 2'd3) begin
            if (pop_entry.fld == FLD_WIDTH) begin
              width_reg_next = sat_dim(field_shift_next);
            end else begin
              height_reg_next = sat_dim(field_shift_next);
            end
          end
        end
        FLD_DEPTH:   depth_reg_next = depth_reg_next | shifted[15:0];
        default:     ;
      endcase
    end else if (phase_next == PH_IDLE && pop_entry.pos == offset_reg_next) begin
      // start of pixel data
      if (width_reg_next == '0 || height_reg_next == '0) begin
        phase_next = PH_DONE;
      end else begin
        phase_next = PH_ACTIVE;
        emit       = 1'b1;
      end
    end

    // pixel coordinates and counter advance
    col_inc = col_next + DIM_W'(1);
    row_inc = row_next + DIM_W'(1);
    if (emit) begin
      prow = 12'(height_reg_next - row_next - DIM_W'(1));
      pcol = col_next[11:0];
      pch  = chan_next;
      if (chan_next == 2'd2) begin
        chan_next = '0;
        if (col_inc >= width_reg_next) begin
          col_next       = '0;
          row_next       = row_inc;
          pad_count_next = width_reg_next[1:0];
          if (width_reg_next[1:0] == 2'd0 && row_inc >= height_reg_next) begin
            phase_next = PH_DONE;
          end
        end else begin
          col_next = col_inc;
        end
      end else begin
        chan_next = chan_next + 2'd1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      field_shift     <= '0;
      type_reg        <= '0;
      size_reg        <= '0;
      offset_reg      <= '0;
      header_size_reg <= '0;
      kind_reg        <= KIND_NONE;
      width_reg       <= '0;
      height_reg      <= '0;
      depth_reg       <= '0;
      row             <= '0;
      col             <= '0;
      chan            <= '0;
      phase           <= PH_IDLE;
      pad_count       <= '0;
    end else if (fire) begin
      field_shift     <= field_shift_next;
      type_reg        <= type_reg_next;
      size_reg        <= size_reg_next;
      offset_reg      <= offset_reg_next;
      header_size_reg <= header_size_reg_next;
      kind_reg        <= kind_reg_next;
      width_reg       <= width_reg_next;
      height_reg      <= height_reg_next;
      depth_reg       <= depth_reg_next;
      row             <= row_next;
      col             <= col_next;
      chan            <= chan_next;
      phase           <= phase_next;
      pad_count       <= pad_count_next;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (fire) begin
      results.pixel_valid   <= emit;
      results.pixel_row     <= prow;
      results.pixel_column  <= pcol;
      results.pixel_channel <= pch;
      results.pixel_value   <= emit ? pop_entry.data_byte : 8'd0;
      results.file_type     <= type_reg_next;
      results.file_size     <= size_reg_next;
      results.image_width   <= width_reg_next;
      results.image_height  <= height_reg_next;
      results.color_depth   <= depth_reg_next;
      results.data_offset   <= offset_reg_next;
      results.header_kind   <= kind_reg_next;
    end
  end

endmodule

### sv/bmp_stream_deframer_unit.sv
// Path: a byte transferred in is written into a queue slot, and from there
// into the result register when the back part pops it.
// Throughput: one byte per cycle while results.ready keeps the output moving;
// the back part's header and pixel-counter state is registered on each byte.
// Reset: synchronous rst clears position, header fields, counters and queue;
// no clearing pass. A file start byte clears the parse state as well.
// ----------------------------------------------------------------------------
// bmp_stream_deframer_unit
// Byte-serial 24-bit BMP deframer: header capture and pixel tagging.
// ----------------------------------------------------------------------------
module bmp_stream_deframer_unit import bmpdf_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  bmpdf_byte_if.sink     file_bytes,
  bmpdf_result_if.source results
);

  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_entry;
  qstat_t qstat;

  // front: position tracking and field tagging
  bmpdf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .file_bytes (file_bytes),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  // decoupling queue
  bmpdf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry),
    .status     (qstat)
  );

  // back: header capture, pixel counters, result register
  bmpdf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .results   (results)
  );

  // queue level never exceeds its depth
  a_qcount_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= QCNT_W'(QDEPTH))
    else $error("queue level above depth");

  // push without pop raises the level by one
  a_qcount_push: assert property (@(posedge clk) disable iff (rst)
    qstat.push && !qstat.pop |=> qstat.count == $past(qstat.count) + QCNT_W'(1))
    else $error("queue level did not follow a transfer in");

  // non-pixel results carry zero pixel fields
  a_nonpixel_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.pixel_valid |->
      results.pixel_value == 8'd0 && results.pixel_row == 12'd0 &&
      results.pixel_column == 12'd0 && results.pixel_channel == 2'd0)
    else $error("pixel fields set on a non-pixel result");

  // channel index stays in range and dimensions are clamped
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> results.pixel_channel != 2'd3 &&
      results.image_width <= DIM_W'(MAX_DIM) &&
      results.image_height <= DIM_W'(MAX_DIM))
    else $error("result field out of range");

endmodule
